// ===== rtl/bvacd_pkg.sv =====
// Shared constants and types for the battery voltage average / charge detect unit.
`timescale 1ns / 1ps

package bvacd_pkg;

    // Field widths
    localparam int CODE_W = 12;
    localparam int RAWV_W = 18;
    localparam int CORR_W = 20;
    localparam int GAIN_W = 16;
    localparam int WIN_W  = 16;

    // Scaling: raw_voltage = code * VOLT_FULL_SCALE / CODE_FULL_SCALE
    localparam logic [RAWV_W-1:0] VOLT_FULL_SCALE = 18'd216269;
    localparam logic [11:0]       CODE_FULL_SCALE = 12'd4095;
    localparam logic [CORR_W-1:0] CORR_MAX        = 20'hFFFFF;
    localparam logic [CORR_W-1:0] TREND_STEP      = 20'd655;

    // Register index codes (byte address / 4)
    localparam logic [1:0] REG_WINDOW_SIZE = 2'd0;
    localparam logic [1:0] REG_CAL_GAIN    = 2'd1;
    localparam logic [1:0] REG_USE_SENSE   = 2'd2;

    // Reset values of the registers
    localparam logic [WIN_W-1:0]  WINDOW_RESET = 16'd8;
    localparam logic [GAIN_W-1:0] GAIN_RESET   = 16'd4096;

    // Result item, filtered_voltage in the low bits
    typedef struct packed {
        logic              charging;
        logic [CODE_W-1:0] raw_code;
        logic [RAWV_W-1:0] raw_voltage;
        logic [CORR_W-1:0] filtered_voltage;
    } out_item_t;

endpackage

// ===== rtl/bvacd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module bvacd_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 32
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/battery_voltage_average_charge_detect_unit.sv =====
// Top level: ADC scaling, gain correction, ring-buffer moving average, charge detect.
`timescale 1ns / 1ps
//
//  channel   | dir | handshake                       | payload
//  ----------+-----+---------------------------------+-----------------------------------
//  s_axis    | in  | s_tvalid / s_tready             | s_tdata: adc_code, sense_level
//  m_axis    | out | m_tvalid / m_tready             | m_tdata: filtered, raw_v, code, chg
//  apb       | in  | psel, penable, pwrite, pready=1 | paddr, pwdata, prdata
//
//  One request at a time: each runs through QEST, QFIX, GAIN, SUM, the bit-serial
//  divide by the fill count (DIV) and DONE before the next accept.
//  Sample store is a RAM read in the cycle before the read-modify-write of the running sum.
//  rst_n resets registers and filter state; mapped register writes clear filter state.
//  The next request is taken while a result waits in the output register; a request
//  only stalls at its final cycle when that register is still full.

module battery_voltage_average_charge_detect_unit #(
    parameter int MAX_WINDOW = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // s_tdata: [11:0] adc_code, [12] sense_level, [15:13] zero
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,
    // m_tdata: [19:0] filtered_voltage, [37:20] raw_voltage, [49:38] raw_code,
    //          [50] charging, [55:51] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import bvacd_pkg::*;

    localparam int CW     = $clog2(MAX_WINDOW + 1);           // fill count / window
    localparam int SLW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SUM_W  = CORR_W + $clog2(MAX_WINDOW);
    localparam int DCNT_W = $clog2(SUM_W + 1);
    localparam int PROD_W = 30;
    localparam int GPROD_W = RAWV_W + GAIN_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_QEST = 3'd1;
    localparam logic [2:0] ST_QFIX = 3'd2;
    localparam logic [2:0] ST_GAIN = 3'd3;
    localparam logic [2:0] ST_SUM  = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    // Control and filter state
    logic [2:0]        state_reg, state_next;
    logic [WIN_W-1:0]  window_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic              use_sense_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [CW-1:0]     fill_reg;
    logic [SLW-1:0]    slot_reg;
    logic [CORR_W-1:0] prev_reg;
    logic              chg_reg;
    logic              seeded_reg;
    logic              out_valid_reg;
    logic [DCNT_W-1:0] dcnt_reg;

    // Payload
    logic [CODE_W-1:0]  code_reg;
    logic               sense_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [RAWV_W-1:0]  qest_reg;
    logic [RAWV_W-1:0]  rawv_reg;
    logic [GPROD_W-1:0] gprod_reg;
    logic [SUM_W-1:0]   divq_reg;
    logic [CW-1:0]      divr_reg;
    out_item_t          out_item_reg;

    logic              s_accept;
    logic              cfg_write;
    logic              cfg_hit;
    logic [CW-1:0]     win_eff;
    logic [PROD_W:0]   qsum;
    logic [PROD_W:0]   qrem;
    logic [RAWV_W-1:0] rawv_next;
    logic [21:0]       gshift;
    logic [CORR_W-1:0] corr;
    logic              filling;
    logic [SUM_W-1:0]  sum_next;
    logic [CW-1:0]     fill_next;
    logic [SLW-1:0]    slot_next;
    logic [CW:0]       dcand;
    logic              dge;
    logic [CORR_W-1:0] filt;
    logic              chg_next;
    logic              out_load;
    logic              mem_re;
    logic              mem_we;
    logic [CORR_W-1:0] mem_rdata;

    assign pready    = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_hit   = cfg_write && (paddr[3:2] == REG_WINDOW_SIZE
                       || paddr[3:2] == REG_CAL_GAIN || paddr[3:2] == REG_USE_SENSE);

    always_comb
    begin
        case (paddr[3:2])
            REG_WINDOW_SIZE: prdata = {16'd0, window_reg};
            REG_CAL_GAIN:    prdata = {16'd0, gain_reg};
            REG_USE_SENSE:   prdata = {31'd0, use_sense_reg};
            default:         prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        if (window_reg == '0)
            win_eff = CW'(1);
        else if (window_reg > WIN_W'(MAX_WINDOW))
            win_eff = CW'(MAX_WINDOW);
        else
            win_eff = CW'(window_reg);
    end

    // x/4095 ~= (x + x/4096)/4096, low by at most one; fixed with one compare
    assign qsum = (PROD_W + 1)'(prod_reg) + (PROD_W + 1)'(prod_reg >> 12);
    assign qrem = (PROD_W + 1)'(prod_reg)
                  - ((PROD_W + 1)'(qest_reg) * (PROD_W + 1)'(CODE_FULL_SCALE));
    assign rawv_next = (qrem >= (PROD_W + 1)'(CODE_FULL_SCALE)) ? qest_reg + RAWV_W'(1)
                                                                : qest_reg;

    assign gshift = gprod_reg[GPROD_W-1:12];
    assign corr   = (gshift > 22'(CORR_MAX)) ? CORR_MAX : gshift[CORR_W-1:0];

    assign filling  = (fill_reg < win_eff);
    assign sum_next = filling ? sum_reg + SUM_W'(corr)
                              : sum_reg - SUM_W'(mem_rdata) + SUM_W'(corr);
    assign fill_next = filling ? fill_reg + CW'(1) : fill_reg;
    assign slot_next = (CW'(slot_reg) + CW'(1) == win_eff) ? '0 : slot_reg + SLW'(1);

    // Restoring divide, one quotient bit per cycle
    assign dcand = {divr_reg, divq_reg[SUM_W-1]};
    assign dge   = (dcand >= {1'b0, fill_reg});

    assign filt = divq_reg[CORR_W-1:0];

    always_comb
    begin
        chg_next = chg_reg;
        if (use_sense_reg)
            chg_next = !sense_reg;
        else if (seeded_reg)
        begin
            if ({1'b0, filt} >= {1'b0, prev_reg} + 21'(TREND_STEP))
                chg_next = 1'b1;
            else if ({1'b0, prev_reg} >= {1'b0, filt} + 21'(TREND_STEP))
                chg_next = 1'b0;
        end
    end

    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_accept) state_next = ST_QEST;
            ST_QEST: state_next = ST_QFIX;
            ST_QFIX: state_next = ST_GAIN;
            ST_GAIN: state_next = ST_SUM;
            ST_SUM:  state_next = ST_DIV;
            ST_DIV:  if (dcnt_reg == DCNT_W'(SUM_W - 1)) state_next = ST_DONE;
            ST_DONE: if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign mem_re = (state_reg == ST_GAIN);
    assign mem_we = (state_reg == ST_SUM);

    bvacd_ram #(
        .WIDTH (CORR_W),
        .DEPTH (MAX_WINDOW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (slot_reg),
        .wdata (corr),
        .re    (mem_re),
        .raddr (slot_reg),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            window_reg    <= WINDOW_RESET;
            gain_reg      <= GAIN_RESET;
            use_sense_reg <= 1'b0;
            sum_reg       <= '0;
            fill_reg      <= '0;
            slot_reg      <= '0;
            prev_reg      <= '0;
            chg_reg       <= 1'b0;
            seeded_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            dcnt_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (state_reg == ST_SUM)
                dcnt_reg <= '0;
            else if (state_reg == ST_DIV)
                dcnt_reg <= dcnt_reg + DCNT_W'(1);

            if (cfg_hit)
            begin
                case (paddr[3:2])
                    REG_WINDOW_SIZE: window_reg    <= pwdata[WIN_W-1:0];
                    REG_CAL_GAIN:    gain_reg      <= pwdata[GAIN_W-1:0];
                    REG_USE_SENSE:   use_sense_reg <= pwdata[0];
                    default:         ;
                endcase
                sum_reg    <= '0;
                fill_reg   <= '0;
                slot_reg   <= '0;
                prev_reg   <= '0;
                chg_reg    <= 1'b0;
                seeded_reg <= 1'b0;
            end
            else
            begin
                if (state_reg == ST_SUM)
                begin
                    sum_reg  <= sum_next;
                    fill_reg <= fill_next;
                    slot_reg <= slot_next;
                end
                if (out_load)
                begin
                    prev_reg   <= filt;
                    chg_reg    <= chg_next;
                    seeded_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            code_reg  <= s_tdata[CODE_W-1:0];
            sense_reg <= s_tdata[CODE_W];
            prod_reg  <= PROD_W'(s_tdata[CODE_W-1:0]) * PROD_W'(VOLT_FULL_SCALE);
        end
        if (state_reg == ST_QEST)
            qest_reg <= RAWV_W'(qsum >> 12);
        if (state_reg == ST_QFIX)
            rawv_reg <= rawv_next;
        if (state_reg == ST_GAIN)
            gprod_reg <= GPROD_W'(rawv_reg) * GPROD_W'(gain_reg);
        if (state_reg == ST_SUM)
        begin
            divq_reg <= sum_next;
            divr_reg <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            divq_reg <= {divq_reg[SUM_W-2:0], dge};
            divr_reg <= dge ? CW'(dcand - {1'b0, fill_reg}) : CW'(dcand);
        end
        if (out_load)
        begin
            out_item_reg.filtered_voltage <= filt;
            out_item_reg.raw_voltage      <= rawv_reg;
            out_item_reg.raw_code         <= code_reg;
            out_item_reg.charging         <= chg_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_item_reg};

    // Fill count never passes the window, and the write slot stays inside it
    a_fill_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= win_eff)
        else $error("fill count beyond window");

    a_slot_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(slot_reg) < win_eff)
        else $error("write slot beyond window");

    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_hit |=> (fill_reg == '0 && sum_reg == '0 && !seeded_reg))
        else $error("register write did not clear filter state");

endmodule

// ===== dv/bvacd_reading_checker.sv =====
// Checker for the battery average unit: predicts every reading and compares results.
`timescale 1ns / 1ps

module bvacd_reading_checker #(
    parameter int MAX_WINDOW = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output int          mismatch_count,
    output int          pending_results
);
    import bvacd_pkg::*;

    // register copies
    logic [WIN_W-1:0]  window_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic              sense_mode;

    // filter and trend state
    logic [CORR_W-1:0] sample_ring [MAX_WINDOW];
    longint unsigned   acc_sum;
    int unsigned       samples_held;
    int unsigned       next_slot;
    int unsigned       last_filtered;
    logic              charge_state;
    logic              trend_armed;

    out_item_t expected_readings[$];

    initial mismatch_count = 0;

    task automatic note_mismatch(input string what, input int unsigned got_v,
                                 input int unsigned want_v);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got_v, want_v, $time);
        mismatch_count++;
    endtask

    function automatic void clear_average();
        foreach (sample_ring[i])
            sample_ring[i] = '0;
        acc_sum       = 0;
        samples_held  = 0;
        next_slot     = 0;
        last_filtered = 0;
        charge_state  = 1'b0;
        trend_armed   = 1'b0;
    endfunction

    function automatic out_item_t predict_reading(input logic [CODE_W-1:0] code,
                                                  input logic sense);
        longint unsigned volts;
        longint unsigned scaled;
        int unsigned     corr;
        int unsigned     win;
        int unsigned     slot;
        int unsigned     filt;
        out_item_t       r;
        volts  = (64'(code) * 64'(VOLT_FULL_SCALE)) / 64'(CODE_FULL_SCALE);
        scaled = (volts * 64'(gain_reg)) >> 12;
        corr   = (scaled > 64'(CORR_MAX)) ? 32'(CORR_MAX) : 32'(scaled);
        if (window_reg == 0)
            win = 1;
        else if (window_reg > MAX_WINDOW)
            win = MAX_WINDOW;
        else
            win = window_reg;
        slot = (next_slot < MAX_WINDOW) ? next_slot : 0;
        if (samples_held < win)
            samples_held++;
        else
            acc_sum -= sample_ring[slot];
        sample_ring[slot] = CORR_W'(corr);
        acc_sum += corr;
        next_slot = (slot + 1) % win;
        filt = 32'(acc_sum / samples_held) & 32'(CORR_MAX);

        if (sense_mode) begin
            charge_state = !sense;
            trend_armed  = 1'b1;
        end else if (!trend_armed) begin
            // first sample after a clear only seeds the trend
            trend_armed = 1'b1;
        end else if (filt >= last_filtered + TREND_STEP) begin
            charge_state = 1'b1;
        end else if (last_filtered >= filt + TREND_STEP) begin
            charge_state = 1'b0;
        end
        last_filtered = filt;

        r.filtered_voltage = CORR_W'(filt);
        r.raw_voltage      = RAWV_W'(volts);
        r.raw_code         = code;
        r.charging         = charge_state;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        out_item_t got;
        out_item_t want;
        if (!rst_n) begin
            window_reg = WINDOW_RESET;
            gain_reg   = GAIN_RESET;
            sense_mode = 1'b0;
            clear_average();
            expected_readings.delete();
        end else begin
            // results leave before new requests are predicted in the same cycle
            if (m_tvalid && m_tready) begin
                got = out_item_t'(m_tdata[$bits(out_item_t)-1:0]);
                if (expected_readings.size() == 0) begin
                    note_mismatch("result with no request pending", got.filtered_voltage, 0);
                end else begin
                    want = expected_readings.pop_front();
                    if (got.filtered_voltage !== want.filtered_voltage)
                        note_mismatch("filtered_voltage", got.filtered_voltage,
                                      want.filtered_voltage);
                    if (got.raw_voltage !== want.raw_voltage)
                        note_mismatch("raw_voltage", got.raw_voltage, want.raw_voltage);
                    if (got.raw_code !== want.raw_code)
                        note_mismatch("raw_code", got.raw_code, want.raw_code);
                    if (got.charging !== want.charging)
                        note_mismatch("charging", got.charging, want.charging);
                end
            end
            if (s_tvalid && s_tready)
                expected_readings.push_back(predict_reading(s_tdata[CODE_W-1:0],
                                                            s_tdata[CODE_W]));
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_WINDOW_SIZE:
                    begin
                        window_reg = pwdata[WIN_W-1:0];
                        clear_average();
                    end
                    REG_CAL_GAIN:
                    begin
                        gain_reg = pwdata[GAIN_W-1:0];
                        clear_average();
                    end
                    REG_USE_SENSE:
                    begin
                        sense_mode = pwdata[0];
                        clear_average();
                    end
                    default:
                    begin
                        // unmapped address: no effect on the filter
                    end
                endcase
            end
        end
        pending_results = expected_readings.size();
    end

endmodule

// ===== dv/battery_voltage_average_charge_detect_unit_tb.sv =====
// Testbench top: clock, reset, stream and register stimulus, and the verdict.
`timescale 1ns / 1ps

module battery_voltage_average_charge_detect_unit_tb;
    import bvacd_pkg::*;

    localparam int MAX_WINDOW  = 32;
    localparam int NUM_PHASES  = 14;
    localparam int LONG_HOLD   = 300;
    localparam logic [1:0] REG_UNMAPPED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int mismatches;
    int pending;

    bit idle_on;
    bit rx_hold_req;

    // -1 picks a random 16-bit value
    int window_plan [NUM_PHASES] = '{8, 0, 1, 32, 65535, 33, 5, 16, -1, 3, 31, 2, -1, 8};
    int gain_plan   [NUM_PHASES] = '{4096, 4096, 65535, 4096, 0, 30000, 4096, -1,
                                     65535, 4096, -1, 4096, -1, 4096};
    int sense_plan  [NUM_PHASES] = '{0, 1, 0, 0, 1, 0, 0, 1, 0, 0, 1, 0, 0, 0};

    logic [CODE_W-1:0] directed_codes [20] = '{12'd0, 12'd4095, 12'd4095, 12'd4095,
                                               12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0,
                                               12'd0, 12'd0, 12'd2000, 12'd2004, 12'd2008,
                                               12'd2012, 12'd2016, 12'd1, 12'd4094, 12'd2048};

    battery_voltage_average_charge_detect_unit #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    bvacd_reading_checker #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .mismatch_count  (mismatches),
        .pending_results (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [15:0] plan_value(input int v);
        return (v < 0) ? 16'($urandom_range(0, 65535)) : 16'(v);
    endfunction

    task automatic send_reading(input logic [CODE_W-1:0] code, input logic sense);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, sense, code};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [3:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end else begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        int level;
        int delta;
        int roll;
        int n_items;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        idle_on     = 1'b1;
        rx_hold_req = 1'b0;
        level       = 2048;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: seed, big rise, big fall, small drift
        foreach (directed_codes[i])
            send_reading(directed_codes[i], i[0]);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            idle_on = (ph % 4 != 2) && (ph < NUM_PHASES - 2);
            if (ph > 0) begin
                drain_results();
                cfg_write({REG_WINDOW_SIZE, 2'b00},
                          {16'($urandom), plan_value(window_plan[ph])});
                cfg_write({REG_CAL_GAIN, 2'b00},
                          {16'($urandom), plan_value(gain_plan[ph])});
                cfg_write({REG_USE_SENSE, 2'b00},
                          {31'($urandom), 1'(sense_plan[ph])});
            end
            n_items = (ph == 0) ? 80 : 100;
            for (int k = 0; k < n_items; k++) begin
                if (ph == 3 && k == 40)
                    rx_hold_req = 1'b1;
                if (ph == 6 && k == 50)
                    drain_results();
                if ((ph == 5 || ph == 9) && k == 50) begin
                    // unmapped write must leave the average running
                    drain_results();
                    cfg_write({REG_UNMAPPED, 2'b00}, $urandom);
                end
                // mostly a slow walk around the trend threshold, some jumps
                roll = $urandom_range(0, 9);
                if (roll < 6)
                    delta = int'($urandom_range(0, 80)) - 40;
                else if (roll < 8)
                    delta = int'($urandom_range(0, 800)) - 400;
                else
                    delta = 0;
                if (roll == 8)
                    level = $urandom_range(0, 4095);
                else if (roll == 9)
                    level = $urandom_range(0, 1) ? 4095 : 0;
                else
                    level = level + delta;
                if (level < 0)
                    level = 0;
                if (level > 4095)
                    level = 4095;
                send_reading(CODE_W'(level), 1'($urandom_range(0, 1)));
            end
        end

        drain_results();
        repeat (64) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("PASS battery_voltage_average_charge_detect_unit");
        else
            $display("FAIL battery_voltage_average_charge_detect_unit");
        $finish;
    end

    initial
    begin : watchdog
        #(64'd5_000_000);
        $display("FAIL battery_voltage_average_charge_detect_unit");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/bvacd_pkg.sv
rtl/bvacd_ram.sv
rtl/battery_voltage_average_charge_detect_unit.sv
dv/bvacd_reading_checker.sv
dv/battery_voltage_average_charge_detect_unit_tb.sv
